[sv/aatr_pkg.sv]
// shared types and defaults for the antialiased line tile rasterizer
`default_nettype none

package aatr_pkg;

    // default geometry and precision
    localparam int TILE_BITS_DEF       = 5;
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int SLOPE_FRAC_BITS_DEF = 16;
    localparam int WEIGHT_BITS_DEF     = 8;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SLOPE,
        ST_OFS,
        ST_ADDY,
        ST_WMUL,
        ST_EMIT,
        ST_MID
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture and order a new segment
        logic div_step;   // one restoring divide step
        logic set_slope;  // form signed slope from quotient
        logic mul_ofs;    // slope times endpoint column offset
        logic add_y;      // endpoint y plus floored offset
        logic mul_w;      // endpoint fraction times x gap
        logic emit_end;   // load endpoint word into output register
        logic emit_mid;   // load interior word, step the accumulator
        logic sel;        // 0: first endpoint, 1: second endpoint
        logic last;       // word closes the line
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic end_last;   // no interior columns after second endpoint
        logic mid_last;   // current interior column is the last one
    } stat_t;

endpackage

`default_nettype wire

[sv/antialiased_line_tile_raster.sv]
// top level of the antialiased line tile rasterizer
//
// Input channel (s_*): one line segment per word, two endpoints in unsigned
// fixed point inside one square tile. Output channel (m_*): one word per
// major-axis column, a base pixel, its weight and the weight of the
// neighbour one step along the minor axis; m_last_pixel marks the final
// word of a segment. Words come out as first endpoint, second endpoint,
// then interior columns in increasing order. Pixels may lie one step
// outside the tile and are left for the consumer to clip.
//
// One segment is in work at a time. After it is taken, the slope divider
// runs its restoring steps and the slope is formed; each endpoint then
// passes through offset multiply, y add, weight multiply and emit, the
// two multiplies sharing one multiplier, and interior columns follow at
// one word per cycle while the receiver does not stall.
// The output register lets the last word wait while the next segment is
// taken. A stalled receiver holds the current word and pauses the column
// sequence. Reset (aresetn low, synchronous) returns the controller to idle
// and empties the output register.
`default_nettype none

module antialiased_line_tile_raster #(
    parameter int TILE_BITS       = aatr_pkg::TILE_BITS_DEF,
    parameter int COORD_FRAC_BITS = aatr_pkg::COORD_FRAC_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = aatr_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int WEIGHT_BITS     = aatr_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_start_x,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_start_y,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_end_x,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_end_y,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [TILE_BITS+1:0]                  m_pixel_x,
    output logic signed [TILE_BITS+1:0]                  m_pixel_y,
    output logic [WEIGHT_BITS-1:0]                       m_weight_near,
    output logic [WEIGHT_BITS-1:0]                       m_weight_far,
    output logic                                         m_along_x,
    output logic                                         m_last_pixel
);

    aatr_pkg::cmd_t  cmd;
    aatr_pkg::stat_t stat;

    // sequencer
    aatr_ctrl #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and output register
    aatr_dpath #(
        .TILE_BITS       (TILE_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_weight_near (m_weight_near),
        .m_weight_far  (m_weight_far),
        .m_along_x     (m_along_x),
        .m_last_pixel  (m_last_pixel)
    );

    // one segment in work at a time
    a_one_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("segment taken while another is in work");

    // a word is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_end || cmd.emit_mid) |-> stat.out_free)
        else $error("word loaded over an unconsumed word");

    // the closing word returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.emit_end || cmd.emit_mid) && cmd.last) |=> s_ready)
        else $error("sequencer not idle after last word");

endmodule

`default_nettype wire

[sv/aatr_ctrl.sv]
// controller state machine sequencing divide, endpoints and interior columns
`default_nettype none

module aatr_ctrl #(
    parameter int SLOPE_FRAC_BITS = aatr_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire aatr_pkg::stat_t stat,
    output aatr_pkg::cmd_t      cmd
);

    localparam int CNTW = $clog2(SLOPE_FRAC_BITS + 2);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(SLOPE_FRAC_BITS);

    aatr_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             sel_reg, sel_next;

    // state, divide counter and endpoint select
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aatr_pkg::ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.sel    = sel_reg;
        case (state_reg)
            aatr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = aatr_pkg::ST_DIV;
                end
            end
            aatr_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = aatr_pkg::ST_SLOPE;
                end
            end
            aatr_pkg::ST_SLOPE: begin
                cmd.set_slope = 1'b1;
                sel_next      = 1'b0;
                state_next    = aatr_pkg::ST_OFS;
            end
            aatr_pkg::ST_OFS: begin
                cmd.mul_ofs = 1'b1;
                state_next  = aatr_pkg::ST_ADDY;
            end
            aatr_pkg::ST_ADDY: begin
                cmd.add_y  = 1'b1;
                state_next = aatr_pkg::ST_WMUL;
            end
            aatr_pkg::ST_WMUL: begin
                cmd.mul_w  = 1'b1;
                state_next = aatr_pkg::ST_EMIT;
            end
            aatr_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_end = 1'b1;
                    if (!sel_reg) begin
                        sel_next   = 1'b1;
                        state_next = aatr_pkg::ST_OFS;
                    end else begin
                        cmd.last   = stat.end_last;
                        state_next = stat.end_last ? aatr_pkg::ST_IDLE : aatr_pkg::ST_MID;
                    end
                end
            end
            aatr_pkg::ST_MID: begin
                if (stat.out_free) begin
                    cmd.emit_mid = 1'b1;
                    cmd.last     = stat.mid_last;
                    if (stat.mid_last) begin
                        state_next = aatr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = aatr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/aatr_dpath.sv]
// datapath: segment ordering, slope divider, shared multiplier, output register
`default_nettype none

module aatr_dpath #(
    parameter int TILE_BITS       = aatr_pkg::TILE_BITS_DEF,
    parameter int COORD_FRAC_BITS = aatr_pkg::COORD_FRAC_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = aatr_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int WEIGHT_BITS     = aatr_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire aatr_pkg::cmd_t                          cmd,
    output aatr_pkg::stat_t                              stat,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_start_x,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_start_y,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_end_x,
    input  wire logic [TILE_BITS+COORD_FRAC_BITS-1:0]    s_end_y,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [TILE_BITS+1:0]                  m_pixel_x,
    output logic signed [TILE_BITS+1:0]                  m_pixel_y,
    output logic [WEIGHT_BITS-1:0]                       m_weight_near,
    output logic [WEIGHT_BITS-1:0]                       m_weight_far,
    output logic                                         m_along_x,
    output logic                                         m_last_pixel
);

    localparam int Q      = SLOPE_FRAC_BITS;
    localparam int W      = WEIGHT_BITS;
    localparam int CW     = TILE_BITS + COORD_FRAC_BITS;
    localparam int UP     = Q - COORD_FRAC_BITS;
    localparam int XQW    = TILE_BITS + Q;
    localparam int XSW    = XQW + 1;
    localparam int XEW    = TILE_BITS + 1;
    localparam int YW     = TILE_BITS + Q + 3;
    localparam int PW     = TILE_BITS + 2;
    localparam int SW     = Q + 2;
    localparam int PRW    = 2 * SW;
    localparam int GW     = Q + 1;
    localparam int EPW    = 2 * Q + 2;
    localparam int SH_END = 2 * Q - W;
    localparam int SH_R   = (Q >= W) ? Q - W : 0;
    localparam int SH_L   = (Q >= W) ? 0 : W - Q;
    localparam int MW     = Q + 1 + SH_L;

    localparam logic [XSW-1:0] HALF_X = XSW'(1) << (Q - 1);
    localparam logic [SW-1:0]  HALF_D = SW'(1) << (Q - 1);
    localparam logic [SW-1:0]  ONE_S  = SW'(1) << Q;
    localparam logic [GW-1:0]  ONE_G  = GW'(1) << Q;
    localparam logic [W-1:0]   WMAX   = '1;

    // endpoint weight: drop 2Q-W fraction bits, saturate
    function automatic logic [W-1:0] sat_end(input logic [EPW-1:0] v);
        logic [EPW-1:0] s;
        s = v >> SH_END;
        return (s > EPW'(WMAX)) ? WMAX : s[W-1:0];
    endfunction

    // interior weight: rescale Q fraction bits to W, saturate
    function automatic logic [W-1:0] sat_mid(input logic [GW-1:0] v);
        logic [MW-1:0] s;
        s = (MW'(v) >> SH_R) << SH_L;
        return (s > MW'(WMAX)) ? WMAX : s[W-1:0];
    endfunction

    // segment registers
    logic                     steep_reg, steep_next;
    logic [CW-1:0]            x0_reg, y0_reg, x1_reg, y1_reg;
    logic [CW-1:0]            x0_next, y0_next, x1_next, y1_next;
    logic [CW-1:0]            dx_reg, dx_next;
    logic                     neg_reg, neg_next;
    logic [CW:0]              rem_reg, rem_next;
    logic [Q:0]               quo_reg, quo_next;
    logic signed [SW-1:0]     slope_reg, slope_next;
    logic signed [PRW-1:0]    prod_reg, prod_next;
    logic signed [YW-1:0]     ye_reg, ye_next;
    logic signed [YW-1:0]     acc_reg, acc_next;
    logic signed [PW-1:0]     col_reg, col_next;
    logic signed [PW-1:0]     stop_reg, stop_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic signed [PW-1:0]     m_pixel_x_reg, m_pixel_x_next;
    logic signed [PW-1:0]     m_pixel_y_reg, m_pixel_y_next;
    logic [W-1:0]             m_weight_near_reg, m_weight_near_next;
    logic [W-1:0]             m_weight_far_reg, m_weight_far_next;
    logic                     m_along_x_reg, m_along_x_next;
    logic                     m_last_pixel_reg, m_last_pixel_next;

    // input ordering
    logic [CW-1:0]            adx, ady, ax0, ay0, ax1, ay1, dmag;
    logic                     steep_in, dneg;

    // divider step
    logic                     div_ge;
    logic [CW:0]              div_r;

    // selected endpoint
    logic [CW-1:0]            ex_sel, ey_sel;
    logic [XSW-1:0]           xsum;
    logic [XEW-1:0]           xe;
    logic [Q-1:0]             xfr;
    logic signed [SW-1:0]     diff;
    logic [GW-1:0]            gap;
    logic signed [PW-1:0]     xe_col;
    logic [YW-1:0]            yq;

    // shared multiplier
    logic signed [SW-1:0]     op_a, op_b;
    logic signed [PRW-1:0]    mul_res;

    // weights and base pixels
    logic [EPW-1:0]           far_end, near_end;
    logic [GW-1:0]            fr_mid;
    logic signed [PW-1:0]     base_end, base_mid;
    logic                     out_free;

    // swap for steep lines, then order by major coordinate
    always_comb begin
        adx      = (s_end_x >= s_start_x) ? s_end_x - s_start_x : s_start_x - s_end_x;
        ady      = (s_end_y >= s_start_y) ? s_end_y - s_start_y : s_start_y - s_end_y;
        steep_in = ady > adx;
        ax0      = steep_in ? s_start_y : s_start_x;
        ay0      = steep_in ? s_start_x : s_start_y;
        ax1      = steep_in ? s_end_y : s_end_x;
        ay1      = steep_in ? s_end_x : s_end_y;
        if (ax0 > ax1) begin
            x0_next = ax1;
            y0_next = ay1;
            x1_next = ax0;
            y1_next = ay0;
        end else begin
            x0_next = ax0;
            y0_next = ay0;
            x1_next = ax1;
            y1_next = ay1;
        end
        dneg = y0_next > y1_next;
        dmag = dneg ? y0_next - y1_next : y1_next - y0_next;
    end

    // restoring divide, one quotient bit per step
    assign div_ge = rem_reg >= {1'b0, dx_reg};
    assign div_r  = div_ge ? rem_reg - {1'b0, dx_reg} : rem_reg;

    // column, fraction and gap of the selected endpoint
    always_comb begin
        ex_sel = cmd.sel ? x1_reg : x0_reg;
        ey_sel = cmd.sel ? y1_reg : y0_reg;
        xsum   = (XSW'(ex_sel) << UP) + HALF_X;
        xe     = xsum[XQW:Q];
        xfr    = xsum[Q-1:0];
        diff   = HALF_D - SW'(xfr);
        gap    = cmd.sel ? GW'(xfr) : ONE_G - GW'(xfr);
        xe_col = $signed(PW'(xe));
        yq     = YW'(ey_sel) << UP;
    end

    // multiplier operands
    always_comb begin
        if (cmd.mul_w) begin
            op_a = $signed(SW'(ye_reg[Q-1:0]));
            op_b = $signed(SW'(gap));
        end else begin
            op_a = slope_reg;
            op_b = diff;
        end
    end
    assign mul_res = op_a * op_b;

    // weights and base pixels
    always_comb begin
        far_end  = prod_reg[EPW-1:0];
        near_end = (EPW'(gap) << Q) - far_end;
        fr_mid   = GW'(acc_reg[Q-1:0]);
        base_end = PW'(ye_reg >>> Q);
        base_mid = PW'(acc_reg >>> Q);
    end

    assign out_free      = !m_valid_reg || m_ready;
    assign stat.out_free = out_free;
    assign stat.end_last = !(col_reg < xe_col);
    assign stat.mid_last = col_reg == stop_reg;

    // working registers
    always_comb begin
        steep_next = steep_reg;
        dx_next    = dx_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        slope_next = slope_reg;
        prod_next  = prod_reg;
        ye_next    = ye_reg;
        acc_next   = acc_reg;
        col_next   = col_reg;
        stop_next  = stop_reg;
        if (cmd.load) begin
            steep_next = steep_in;
            dx_next    = x1_next - x0_next;
            neg_next   = dneg;
            rem_next   = {1'b0, dmag};
            quo_next   = '0;
        end
        if (cmd.div_step) begin
            rem_next = {div_r[CW-1:0], 1'b0};
            quo_next = {quo_reg[Q-1:0], div_ge};
        end
        if (cmd.set_slope) begin
            if (dx_reg == '0) begin
                slope_next = ONE_S;
            end else if (neg_reg) begin
                slope_next = -$signed({1'b0, quo_reg});
            end else begin
                slope_next = $signed({1'b0, quo_reg});
            end
        end
        if (cmd.mul_ofs || cmd.mul_w) begin
            prod_next = mul_res;
        end
        if (cmd.add_y) begin
            ye_next = $signed(yq) + YW'(prod_reg >>> Q);
        end
        if (cmd.emit_end && !cmd.sel) begin
            acc_next = ye_reg + YW'(slope_reg);
            col_next = xe_col + PW'(1);
        end
        if (cmd.emit_end && cmd.sel) begin
            stop_next = xe_col - PW'(1);
        end
        if (cmd.emit_mid) begin
            acc_next = acc_reg + YW'(slope_reg);
            col_next = col_reg + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        steep_reg <= steep_next;
        x0_reg    <= cmd.load ? x0_next : x0_reg;
        y0_reg    <= cmd.load ? y0_next : y0_reg;
        x1_reg    <= cmd.load ? x1_next : x1_reg;
        y1_reg    <= cmd.load ? y1_next : y1_reg;
        dx_reg    <= dx_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        slope_reg <= slope_next;
        prod_reg  <= prod_next;
        ye_reg    <= ye_next;
        acc_reg   <= acc_next;
        col_reg   <= col_next;
        stop_reg  <= stop_next;
    end

    // output word
    always_comb begin
        m_valid_next       = m_valid_reg && !m_ready;
        m_pixel_x_next     = m_pixel_x_reg;
        m_pixel_y_next     = m_pixel_y_reg;
        m_weight_near_next = m_weight_near_reg;
        m_weight_far_next  = m_weight_far_reg;
        m_along_x_next     = m_along_x_reg;
        m_last_pixel_next  = m_last_pixel_reg;
        if (cmd.emit_end) begin
            m_valid_next       = 1'b1;
            m_pixel_x_next     = steep_reg ? base_end : xe_col;
            m_pixel_y_next     = steep_reg ? xe_col : base_end;
            m_weight_near_next = sat_end(near_end);
            m_weight_far_next  = sat_end(far_end);
            m_along_x_next     = steep_reg;
            m_last_pixel_next  = cmd.last;
        end else if (cmd.emit_mid) begin
            m_valid_next       = 1'b1;
            m_pixel_x_next     = steep_reg ? base_mid : col_reg;
            m_pixel_y_next     = steep_reg ? col_reg : base_mid;
            m_weight_near_next = sat_mid(ONE_G - fr_mid);
            m_weight_far_next  = sat_mid(fr_mid);
            m_along_x_next     = steep_reg;
            m_last_pixel_next  = cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pixel_x_reg     <= m_pixel_x_next;
        m_pixel_y_reg     <= m_pixel_y_next;
        m_weight_near_reg <= m_weight_near_next;
        m_weight_far_reg  <= m_weight_far_next;
        m_along_x_reg     <= m_along_x_next;
        m_last_pixel_reg  <= m_last_pixel_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_pixel_x_reg;
    assign m_pixel_y     = m_pixel_y_reg;
    assign m_weight_near = m_weight_near_reg;
    assign m_weight_far  = m_weight_far_reg;
    assign m_along_x     = m_along_x_reg;
    assign m_last_pixel  = m_last_pixel_reg;

endmodule

`default_nettype wire
